// ----- design/nsp_pkg.sv -----
// ============================================================================
// nsp_pkg
// Shared types and sizes for the nested scope time profiler.
// ============================================================================
`default_nettype none

package nsp_pkg;

    // Table and stack sizes
    localparam int SITE_COUNT  = 256;
    localparam int STACK_DEPTH = 16;

    // Field widths
    localparam int SITE_W  = 8;
    localparam int TIME_W  = 64;
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);

    // Frames below the top one live in a small register array
    localparam int UNDER_DEPTH = STACK_DEPTH - 1;
    localparam int UIDX_W      = $clog2(UNDER_DEPTH);

    // Event codes
    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Per-site counters, as stored in the table
    typedef struct packed {
        logic [TIME_W-1:0] excl;
        logic [TIME_W-1:0] total;
        logic [TIME_W-1:0] samples;
    } cnt_t;

    localparam int CNT_W = $bits(cnt_t);

    // Request from the stack stage to the counter table
    typedef struct packed {
        status_t           status;
        logic [SITE_W-1:0] site;
        logic              upd;    // add one sample to the site
        logic              zero;   // report all zeros (exit on empty stack)
        logic [TIME_W-1:0] incl;
        logic [TIME_W-1:0] excl;
    } req_t;

    // Finished result word
    typedef struct packed {
        status_t           status;
        logic [SITE_W-1:0] site;
        cnt_t              cnt;
    } result_t;

endpackage

`default_nettype wire

// ----- design/nested_scope_time_profiler.sv -----
// ============================================================================
// nested_scope_time_profiler
// Hierarchical inclusive and exclusive time profiler over a stack of scopes.
// ============================================================================
// Takes one event word per cycle, sustained while results are accepted, and
// returns one result word per event. The event goes into an input register,
// where the scope stack (top frame in registers, older frames in a small
// array) is updated; the next stage finishes the read-modify-write of the site
// counter table, a RAM with a registered read whose last write is forwarded,
// so events for the same site may follow each other in consecutive cycles.
// The counter table reads as zero after reset through one valid flag per
// site; there is no clearing pass and events are taken from the first cycle
// after reset. Back pressure on the result side stalls the pipeline only
// once all stages hold a word.
`default_nettype none

module nested_scope_time_profiler (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // event words
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,  // site_id[7:0], now[71:8]
    input  wire logic [1:0]   s_axis_tuser,  // opcode[1:0]
    // result words
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [199:0]      m_axis_tdata,  // out_site[7:0], sample_count[71:8],
                                             // total_time[135:72],
                                             // exclusive_time[199:136]
    output logic [1:0]        m_axis_tuser   // status[1:0]
);

    import nsp_pkg::*;

    // Input stage
    logic              a_valid_reg;
    logic [1:0]        a_op_reg;
    logic [SITE_W-1:0] a_site_reg;
    logic [TIME_W-1:0] a_now_reg;

    // Output stage
    logic              m_valid_reg;
    result_t           m_res_reg;

    req_t              req;
    result_t           b_res;
    logic              b_valid;
    logic              ready_out, ready_b, adv_a, adv_b, accept;

    // Pipeline flow control
    assign ready_out     = !m_valid_reg || m_axis_tready;
    assign adv_b         = b_valid && ready_out;
    assign ready_b       = !b_valid || ready_out;
    assign adv_a         = a_valid_reg && ready_b;
    assign s_axis_tready = !a_valid_reg || ready_b;
    assign accept        = s_axis_tvalid && s_axis_tready;

    nsp_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (adv_a),
        .a_op    (a_op_reg),
        .a_site  (a_site_reg),
        .a_now   (a_now_reg),
        .req     (req)
    );

    nsp_site_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (adv_a),
        .req     (req),
        .take    (adv_b),
        .b_valid (b_valid),
        .res     (b_res)
    );

    // Input and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_valid_reg <= 1'b1;
            end else if (adv_a) begin
                a_valid_reg <= 1'b0;
            end
            if (adv_b) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            a_op_reg   <= s_axis_tuser;
            a_site_reg <= s_axis_tdata[SITE_W-1:0];
            a_now_reg  <= s_axis_tdata[SITE_W +: TIME_W];
        end
        if (adv_b) begin
            m_res_reg <= b_res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = {m_res_reg.cnt.excl, m_res_reg.cnt.total,
                            m_res_reg.cnt.samples, m_res_reg.site};

endmodule

`default_nettype wire

// ----- design/nsp_ram.sv -----
// ============================================================================
// nsp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module nsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/nsp_stack.sv -----
// ============================================================================
// nsp_stack
// Scope stack: top frame in registers, older frames in a small array.
// ============================================================================
`default_nettype none

module nsp_stack (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       commit,
    input  wire logic [1:0]                 a_op,
    input  wire logic [nsp_pkg::SITE_W-1:0] a_site,
    input  wire logic [nsp_pkg::TIME_W-1:0] a_now,
    output nsp_pkg::req_t                   req
);

    import nsp_pkg::*;

    // The top frame keeps an exclusive base: exclusive time so far is now - base
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [SITE_W-1:0]  top_site_reg, top_site_next;
    logic [TIME_W-1:0]  top_start_reg, top_start_next;
    logic [TIME_W-1:0]  top_base_reg, top_base_next;

    logic [SITE_W-1:0]  under_site_reg  [UNDER_DEPTH];
    logic [TIME_W-1:0]  under_start_reg [UNDER_DEPTH];
    logic [TIME_W-1:0]  under_excl_reg  [UNDER_DEPTH];

    logic [LEVEL_W-1:0] level_m1, level_m2;
    logic [UIDX_W-1:0]  push_idx, pop_idx;
    logic               push_we;
    logic [TIME_W-1:0]  incl_now, excl_now;

    assign level_m1 = level_reg - LEVEL_W'(1);
    assign level_m2 = level_reg - LEVEL_W'(2);
    assign push_idx = level_m1[UIDX_W-1:0];
    assign pop_idx  = level_m2[UIDX_W-1:0];
    assign incl_now = a_now - top_start_reg;
    assign excl_now = a_now - top_base_reg;

    // Event decode and next stack state
    always_comb begin
        level_next     = level_reg;
        top_site_next  = top_site_reg;
        top_start_next = top_start_reg;
        top_base_next  = top_base_reg;
        push_we        = 1'b0;
        req.status     = ST_OK;
        req.site       = a_site;
        req.upd        = 1'b0;
        req.zero       = 1'b0;
        req.incl       = incl_now;
        req.excl       = excl_now;
        unique case (a_op)
            OP_ENTER: begin
                if (level_reg == LEVEL_W'(STACK_DEPTH)) begin
                    req.status = ST_FULL;
                end else begin
                    push_we        = (level_reg != '0);
                    top_site_next  = a_site;
                    top_start_next = a_now;
                    top_base_next  = a_now;
                    level_next     = level_reg + LEVEL_W'(1);
                end
            end
            OP_EXIT: begin
                if (level_reg == '0) begin
                    req.status = ST_EMPTY;
                    req.zero   = 1'b1;
                    req.site   = '0;
                end else begin
                    req.upd    = 1'b1;
                    req.site   = top_site_reg;
                    level_next = level_m1;
                    // parent becomes top; its exclusive timer resumes now
                    if (level_reg > LEVEL_W'(1)) begin
                        top_site_next  = under_site_reg[pop_idx];
                        top_start_next = under_start_reg[pop_idx];
                        top_base_next  = a_now - under_excl_reg[pop_idx];
                    end
                end
            end
            OP_READ: begin
            end
            default: begin
            end
        endcase
    end

    // Stack state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (commit) begin
            level_reg <= level_next;
        end
        if (commit) begin
            top_site_reg  <= top_site_next;
            top_start_reg <= top_start_next;
            top_base_reg  <= top_base_next;
            if (push_we) begin
                under_site_reg[push_idx]  <= top_site_reg;
                under_start_reg[push_idx] <= top_start_reg;
                under_excl_reg[push_idx]  <= excl_now;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Depth never goes past the stack size
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_W'(STACK_DEPTH))
        else $error("stack level out of range");

    // A counted exit pops exactly one frame
    a_exit_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && req.upd |=> level_reg == $past(level_m1))
        else $error("exit did not pop one frame");

    // A refused event leaves the depth alone
    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && (req.status == ST_FULL || req.status == ST_EMPTY)
        |=> level_reg == $past(level_reg))
        else $error("refused event changed the stack");
`endif

endmodule

`default_nettype wire

// ----- design/nsp_site_table.sv -----
// ============================================================================
// nsp_site_table
// Per-site counter table: registered read, update, write back with forwarding.
// ============================================================================
`default_nettype none

module nsp_site_table (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire nsp_pkg::req_t req,
    input  wire logic       take,
    output logic            b_valid,
    output nsp_pkg::result_t res
);

    import nsp_pkg::*;

    // Second stage: request waiting on the table read
    logic                  b_valid_reg;
    req_t                  b_req_reg;
    logic                  b_hit_reg;

    // One valid flag per site; a clear flag reads as zero counters
    logic [SITE_COUNT-1:0] valid_reg;

    // Last write, for the read that crossed it
    logic                  fwd_valid_reg;
    logic [SITE_W-1:0]     fwd_addr_reg;
    cnt_t                  fwd_data_reg;

    cnt_t                  ram_q;
    cnt_t                  cur;
    cnt_t                  upd_cnt;
    logic                  wr_en;

    assign wr_en = take && b_req_reg.upd;

    nsp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SITE_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (b_req_reg.site),
        .wdata (upd_cnt),
        .re    (load),
        .raddr (req.site),
        .rdata (ram_q)
    );

    // Current counters and their update
    always_comb begin
        if (fwd_valid_reg && fwd_addr_reg == b_req_reg.site) begin
            cur = fwd_data_reg;
        end else if (b_hit_reg) begin
            cur = ram_q;
        end else begin
            cur = '0;
        end
        upd_cnt.samples = cur.samples + TIME_W'(1);
        upd_cnt.total   = cur.total + b_req_reg.incl;
        upd_cnt.excl    = cur.excl + b_req_reg.excl;
    end

    // Result word
    always_comb begin
        res.status = b_req_reg.status;
        res.site   = b_req_reg.site;
        if (b_req_reg.zero) begin
            res.cnt = '0;
        end else if (b_req_reg.upd) begin
            res.cnt = upd_cnt;
        end else begin
            res.cnt = cur;
        end
    end

    assign b_valid = b_valid_reg;

    // Stage register, valid flags and forwarding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                b_valid_reg <= 1'b1;
            end else if (take) begin
                b_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[b_req_reg.site] <= 1'b1;
                fwd_valid_reg             <= 1'b1;
            end
        end
        if (load) begin
            b_req_reg <= req;
            b_hit_reg <= valid_reg[req.site];
        end
        if (wr_en) begin
            fwd_addr_reg <= b_req_reg.site;
            fwd_data_reg <= upd_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    // The stage is never overwritten while it holds an unsent word
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !b_valid_reg || take)
        else $error("counter stage overwritten");

    // A write marks its site valid on the next cycle
    a_valid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> valid_reg[fwd_addr_reg] && fwd_valid_reg)
        else $error("written site not marked valid");

    // An update reports exactly one more sample than the stored count
    a_one_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_req_reg.upd |-> res.cnt.samples == cur.samples + TIME_W'(1))
        else $error("sample count not advanced by one");
`endif

endmodule

`default_nettype wire
